// ===== rtl/egsv_pkg.sv =====
// ============================================================================
// egsv_pkg
// Shared types and codes for the ElGamal signing and checking unit.
// ============================================================================
package egsv_pkg;

    localparam int DEF_MOD_BITS = 32;
    localparam int FIELD_BITS   = 32;
    localparam int ADDR_BITS    = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_PRIME     = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PRIVATE   = 2'd2;

    typedef logic [2:0] sel_t;

    // Divider operand selections.
    localparam sel_t DV_G_P    = 3'd0;
    localparam sel_t DV_M_N    = 3'd1;
    localparam sel_t DV_X_N    = 3'd2;
    localparam sel_t DV_R_N    = 3'd3;
    localparam sel_t DV_K_N    = 3'd4;
    localparam sel_t DV_EUCLID = 3'd5;

    // Modular multiplier operand selections.
    localparam sel_t MM_POW_ACC = 3'd0;
    localparam sel_t MM_POW_SQ  = 3'd1;
    localparam sel_t MM_XR      = 3'd2;
    localparam sel_t MM_EUCLID  = 3'd3;
    localparam sel_t MM_S       = 3'd4;
    localparam sel_t MM_LHS     = 3'd5;

    // Exponentiation selections.
    localparam sel_t PW_Y = 3'd0;
    localparam sel_t PW_R = 3'd1;
    localparam sel_t PW_A = 3'd2;
    localparam sel_t PW_B = 3'd3;
    localparam sel_t PW_G = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_STORE,
        OP_MM_START,
        OP_MM_STORE,
        OP_POW_INIT,
        OP_POW_STORE,
        OP_KINV,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t  op;
        sel_t sel;
    } egsv_cmd_t;

    typedef struct packed {
        logic mm_busy;
        logic dv_busy;
        logic exp_zero;
        logic exp_lsb;
        logic p_lt2;
        logic n_lt2;
        logic r1_zero;
        logic r0_one;
        logic out_free;
    } egsv_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_NEXT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DIV_PUT,
        ST_MM_GO,
        ST_MM_WAIT,
        ST_MM_PUT,
        ST_POW_INIT,
        ST_POW_CHK,
        ST_POW_MGO,
        ST_POW_MWAIT,
        ST_POW_MPUT,
        ST_POW_SGO,
        ST_POW_SWAIT,
        ST_POW_SPUT,
        ST_POW_PUT,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        PH_GRED,
        PH_POW_Y,
        PH_POW_R,
        PH_KRED,
        PH_EU_CHK,
        PH_EU_DIV,
        PH_EU_MM,
        PH_MRED,
        PH_XRED,
        PH_RRED,
        PH_DIFF,
        PH_S,
        PH_POW_A,
        PH_POW_B,
        PH_LHS,
        PH_POW_G
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DIV,
        KIND_MM,
        KIND_POW,
        KIND_CHK
    } kind_t;

endpackage

// ===== rtl/egsv_ctrl.sv =====
// ============================================================================
// egsv_ctrl
// Sequencer that steps the datapath through key generation, signing and
// checking of one item.
// ============================================================================
module egsv_ctrl
    import egsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  egsv_stat_t stat,
    output egsv_cmd_t  cmd
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    function automatic kind_t phase_kind(input phase_t ph);
        kind_t k;
        case (ph)
            PH_GRED, PH_KRED, PH_EU_DIV, PH_MRED, PH_XRED, PH_RRED: k = KIND_DIV;
            PH_EU_MM, PH_DIFF, PH_S, PH_LHS:                        k = KIND_MM;
            PH_EU_CHK:                                               k = KIND_CHK;
            default:                                                 k = KIND_POW;
        endcase
        return k;
    endfunction

    function automatic sel_t phase_sel(input phase_t ph);
        sel_t s;
        case (ph)
            PH_GRED:   s = DV_G_P;
            PH_KRED:   s = DV_K_N;
            PH_EU_DIV: s = DV_EUCLID;
            PH_MRED:   s = DV_M_N;
            PH_XRED:   s = DV_X_N;
            PH_RRED:   s = DV_R_N;
            PH_EU_MM:  s = MM_EUCLID;
            PH_DIFF:   s = MM_XR;
            PH_S:      s = MM_S;
            PH_LHS:    s = MM_LHS;
            PH_POW_Y:  s = PW_Y;
            PH_POW_R:  s = PW_R;
            PH_POW_A:  s = PW_A;
            PH_POW_B:  s = PW_B;
            PH_POW_G:  s = PW_G;
            default:   s = PW_Y;
        endcase
        return s;
    endfunction

    function automatic phase_t phase_succ(input phase_t ph);
        phase_t n;
        case (ph)
            PH_GRED:  n = PH_POW_Y;
            PH_POW_Y: n = PH_POW_R;
            PH_POW_R: n = PH_KRED;
            PH_KRED:  n = PH_EU_CHK;
            PH_EU_DIV: n = PH_EU_MM;
            PH_EU_MM: n = PH_EU_CHK;
            PH_MRED:  n = PH_XRED;
            PH_XRED:  n = PH_RRED;
            PH_RRED:  n = PH_DIFF;
            PH_DIFF:  n = PH_S;
            PH_S:     n = PH_POW_A;
            PH_POW_A: n = PH_POW_B;
            PH_POW_B: n = PH_LHS;
            PH_LHS:   n = PH_POW_G;
            default:  n = PH_POW_G;
        endcase
        return n;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_GRED;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                phase_next = PH_GRED;
                state_next = stat.p_lt2 ? ST_FIN : ST_NEXT;
            end
            ST_NEXT:
            begin
                case (phase_kind(phase_reg))
                    KIND_DIV: state_next = ST_DIV_GO;
                    KIND_MM:  state_next = ST_MM_GO;
                    KIND_POW: state_next = ST_POW_INIT;
                    default:
                    begin
                        if (stat.r1_zero)
                        begin
                            if (stat.r0_one)
                                phase_next = PH_MRED;
                            else
                                state_next = ST_FIN;
                        end
                        else
                            phase_next = PH_EU_DIV;
                    end
                endcase
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!stat.dv_busy)
                    state_next = ST_DIV_PUT;
            end
            ST_MM_GO:    state_next = ST_MM_WAIT;
            ST_MM_WAIT:
            begin
                if (!stat.mm_busy)
                    state_next = ST_MM_PUT;
            end
            ST_POW_INIT: state_next = ST_POW_CHK;
            ST_POW_CHK:
            begin
                if (stat.exp_zero)
                    state_next = ST_POW_PUT;
                else if (stat.exp_lsb)
                    state_next = ST_POW_MGO;
                else
                    state_next = ST_POW_SGO;
            end
            ST_POW_MGO:  state_next = ST_POW_MWAIT;
            ST_POW_MWAIT:
            begin
                if (!stat.mm_busy)
                    state_next = ST_POW_MPUT;
            end
            ST_POW_MPUT: state_next = ST_POW_SGO;
            ST_POW_SGO:  state_next = ST_POW_SWAIT;
            ST_POW_SWAIT:
            begin
                if (!stat.mm_busy)
                    state_next = ST_POW_SPUT;
            end
            ST_POW_SPUT: state_next = ST_POW_CHK;
            ST_DIV_PUT, ST_MM_PUT, ST_POW_PUT:
            begin
                phase_next = phase_succ(phase_reg);
                // With p equal to two there is no inverse to look for.
                if ((phase_reg == PH_POW_R && stat.n_lt2) || phase_reg == PH_POW_G)
                    state_next = ST_FIN;
                else
                    state_next = ST_NEXT;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.sel  = phase_sel(phase_reg);
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            ST_NEXT:
            begin
                if (phase_kind(phase_reg) == KIND_CHK && stat.r1_zero && stat.r0_one)
                    cmd.op = OP_KINV;
            end
            ST_DIV_GO:   cmd.op = OP_DIV_START;
            ST_DIV_PUT:  cmd.op = OP_DIV_STORE;
            ST_MM_GO:    cmd.op = OP_MM_START;
            ST_MM_PUT:   cmd.op = OP_MM_STORE;
            ST_POW_INIT: cmd.op = OP_POW_INIT;
            ST_POW_PUT:  cmd.op = OP_POW_STORE;
            ST_POW_MGO:
            begin
                cmd.op  = OP_MM_START;
                cmd.sel = MM_POW_ACC;
            end
            ST_POW_MPUT:
            begin
                cmd.op  = OP_MM_STORE;
                cmd.sel = MM_POW_ACC;
            end
            ST_POW_SGO:
            begin
                cmd.op  = OP_MM_START;
                cmd.sel = MM_POW_SQ;
            end
            ST_POW_SPUT:
            begin
                cmd.op  = OP_MM_STORE;
                cmd.sel = MM_POW_SQ;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                    cmd.op = OP_PUBLISH;
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/egsv_dpath.sv =====
// ============================================================================
// egsv_dpath
// Operand registers, a shift-and-add modular multiplier, a restoring divider
// and the output register of the signing unit.
// ============================================================================
module egsv_dpath
    import egsv_pkg::*;
#(
    parameter int MOD_BITS = DEF_MOD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  egsv_cmd_t             cmd,
    output egsv_stat_t            stat,
    input  logic [FIELD_BITS-1:0] cfg_prime,
    input  logic [FIELD_BITS-1:0] cfg_generator,
    input  logic [FIELD_BITS-1:0] cfg_private,
    input  logic [FIELD_BITS-1:0] message,
    input  logic [FIELD_BITS-1:0] nonce_k,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FIELD_BITS-1:0] public_key,
    output logic [FIELD_BITS-1:0] sig_r,
    output logic [FIELD_BITS-1:0] sig_s,
    output logic                  verify_ok,
    output logic                  no_inverse
);

    localparam int W  = MOD_BITS;
    localparam int CW = $clog2(W + 1);

    typedef logic [W-1:0] word_t;

    function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
        logic [W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, m})
            sum = sum - {1'b0, m};
        return sum[W-1:0];
    endfunction

    function automatic word_t sub_mod(input word_t a, input word_t b, input word_t m);
        logic [W:0] d;
        if (a >= b)
            d = {1'b0, a} - {1'b0, b};
        else
            d = {1'b0, a} + {1'b0, m} - {1'b0, b};
        return d[W-1:0];
    endfunction

    // Operand and intermediate registers.
    word_t p_reg, n_reg, g_reg, x_reg, m_reg, k_reg;
    word_t gred_reg, mred_reg, xred_reg, rred_reg;
    word_t y_reg, r_reg, s_reg, kinv_reg, diff_reg, lhs_reg, pa_reg, pb_reg;
    word_t r0_reg, r1_reg, t0_reg, t1_reg, q_reg, nr_reg;
    logic  ok_reg, noinv_reg;
    word_t pw_base_reg, pw_exp_reg, pw_acc_reg;

    // Multiplier and divider.
    word_t mm_a_reg, mm_b_reg, mm_m_reg, mm_acc_reg;
    logic  mm_busy_reg;
    word_t dv_quo_reg, dv_den_reg, dv_rem_reg;
    logic [CW-1:0] dv_cnt_reg;
    logic  dv_busy_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [FIELD_BITS-1:0] o_y_reg, o_r_reg, o_s_reg;
    logic                  o_ok_reg, o_noinv_reg;

    word_t mm_a_start, mm_b_start, mm_m_start;
    word_t dv_num_start, dv_den_start;
    word_t pw_base_start, pw_exp_start;
    word_t q_red;
    logic [W:0] dv_trial;
    logic       dv_ge;

    // The Euclid quotient never exceeds n, so one subtraction reduces it.
    assign q_red = (q_reg >= n_reg) ? (q_reg - n_reg) : q_reg;

    always_comb
    begin
        case (cmd.sel)
            MM_POW_ACC:
            begin
                mm_a_start = pw_acc_reg;  mm_b_start = pw_base_reg; mm_m_start = p_reg;
            end
            MM_POW_SQ:
            begin
                mm_a_start = pw_base_reg; mm_b_start = pw_base_reg; mm_m_start = p_reg;
            end
            MM_XR:
            begin
                mm_a_start = xred_reg;    mm_b_start = rred_reg;    mm_m_start = n_reg;
            end
            MM_EUCLID:
            begin
                mm_a_start = q_red;       mm_b_start = t1_reg;      mm_m_start = n_reg;
            end
            MM_S:
            begin
                mm_a_start = diff_reg;    mm_b_start = kinv_reg;    mm_m_start = n_reg;
            end
            default:
            begin
                mm_a_start = pa_reg;      mm_b_start = pb_reg;      mm_m_start = p_reg;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.sel)
            DV_G_P:
            begin
                dv_num_start = g_reg;  dv_den_start = p_reg;
            end
            DV_M_N:
            begin
                dv_num_start = m_reg;  dv_den_start = n_reg;
            end
            DV_X_N:
            begin
                dv_num_start = x_reg;  dv_den_start = n_reg;
            end
            DV_R_N:
            begin
                dv_num_start = r_reg;  dv_den_start = n_reg;
            end
            DV_K_N:
            begin
                dv_num_start = k_reg;  dv_den_start = n_reg;
            end
            default:
            begin
                dv_num_start = r0_reg; dv_den_start = r1_reg;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.sel)
            PW_Y:
            begin
                pw_base_start = gred_reg; pw_exp_start = x_reg;
            end
            PW_R:
            begin
                pw_base_start = gred_reg; pw_exp_start = k_reg;
            end
            PW_A:
            begin
                pw_base_start = y_reg;    pw_exp_start = r_reg;
            end
            PW_B:
            begin
                pw_base_start = r_reg;    pw_exp_start = s_reg;
            end
            default:
            begin
                pw_base_start = gred_reg; pw_exp_start = m_reg;
            end
        endcase
    end

    assign dv_trial = {dv_rem_reg, dv_quo_reg[W-1]};
    assign dv_ge    = dv_trial >= {1'b0, dv_den_reg};

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_busy_reg   <= 1'b0;
            dv_busy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_MM_START)
                mm_busy_reg <= 1'b1;
            else if (mm_b_reg == '0)
                mm_busy_reg <= 1'b0;

            if (cmd.op == OP_DIV_START)
                dv_busy_reg <= 1'b1;
            else if (dv_cnt_reg == CW'(1))
                dv_busy_reg <= 1'b0;

            if (cmd.op == OP_PUBLISH)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Multiplier: one bit of the multiplier operand per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MM_START)
        begin
            mm_a_reg   <= mm_a_start;
            mm_b_reg   <= mm_b_start;
            mm_m_reg   <= mm_m_start;
            mm_acc_reg <= '0;
        end
        else if (mm_busy_reg && mm_b_reg != '0)
        begin
            if (mm_b_reg[0])
                mm_acc_reg <= add_mod(mm_acc_reg, mm_a_reg, mm_m_reg);
            mm_a_reg <= add_mod(mm_a_reg, mm_a_reg, mm_m_reg);
            mm_b_reg <= mm_b_reg >> 1;
        end
    end

    // Divider: one quotient bit per cycle, MSB first.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV_START)
        begin
            dv_quo_reg <= dv_num_start;
            dv_den_reg <= dv_den_start;
            dv_rem_reg <= '0;
            dv_cnt_reg <= CW'(W);
        end
        else if (dv_busy_reg)
        begin
            dv_rem_reg <= dv_ge ? (dv_trial[W-1:0] - dv_den_reg) : dv_trial[W-1:0];
            dv_quo_reg <= {dv_quo_reg[W-2:0], dv_ge};
            dv_cnt_reg <= dv_cnt_reg - CW'(1);
        end
    end

    // Operand registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                p_reg     <= W'(cfg_prime);
                n_reg     <= W'(cfg_prime) - W'(1);
                g_reg     <= W'(cfg_generator);
                x_reg     <= W'(cfg_private);
                m_reg     <= W'(message);
                k_reg     <= W'(nonce_k);
                y_reg     <= '0;
                r_reg     <= '0;
                s_reg     <= '0;
                ok_reg    <= 1'b0;
                noinv_reg <= 1'b1;
            end
            OP_DIV_STORE:
            begin
                case (cmd.sel)
                    DV_G_P: gred_reg <= dv_rem_reg;
                    DV_M_N: mred_reg <= dv_rem_reg;
                    DV_X_N: xred_reg <= dv_rem_reg;
                    DV_R_N: rred_reg <= dv_rem_reg;
                    DV_K_N:
                    begin
                        r0_reg <= n_reg;
                        r1_reg <= dv_rem_reg;
                        t0_reg <= '0;
                        t1_reg <= W'(1);
                    end
                    default:
                    begin
                        q_reg  <= dv_quo_reg;
                        nr_reg <= dv_rem_reg;
                    end
                endcase
            end
            OP_MM_STORE:
            begin
                case (cmd.sel)
                    MM_POW_ACC: pw_acc_reg <= mm_acc_reg;
                    MM_POW_SQ:
                    begin
                        pw_base_reg <= mm_acc_reg;
                        pw_exp_reg  <= pw_exp_reg >> 1;
                    end
                    MM_XR: diff_reg <= sub_mod(mred_reg, mm_acc_reg, n_reg);
                    MM_EUCLID:
                    begin
                        r0_reg <= r1_reg;
                        r1_reg <= nr_reg;
                        t0_reg <= t1_reg;
                        t1_reg <= sub_mod(t0_reg, mm_acc_reg, n_reg);
                    end
                    MM_S:
                    begin
                        // A zero signature is reported as p-1.
                        s_reg     <= (mm_acc_reg == '0) ? n_reg : mm_acc_reg;
                        noinv_reg <= 1'b0;
                    end
                    default: lhs_reg <= mm_acc_reg;
                endcase
            end
            OP_POW_INIT:
            begin
                pw_base_reg <= pw_base_start;
                pw_exp_reg  <= pw_exp_start;
                pw_acc_reg  <= W'(1);
            end
            OP_POW_STORE:
            begin
                case (cmd.sel)
                    PW_Y:    y_reg  <= pw_acc_reg;
                    PW_R:    r_reg  <= pw_acc_reg;
                    PW_A:    pa_reg <= pw_acc_reg;
                    PW_B:    pb_reg <= pw_acc_reg;
                    default: ok_reg <= (lhs_reg == pw_acc_reg);
                endcase
            end
            OP_KINV: kinv_reg <= t0_reg;
            default: kinv_reg <= kinv_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUBLISH)
        begin
            o_y_reg     <= FIELD_BITS'(y_reg);
            o_r_reg     <= FIELD_BITS'(r_reg);
            o_s_reg     <= FIELD_BITS'(s_reg);
            o_ok_reg    <= ok_reg;
            o_noinv_reg <= noinv_reg;
        end
    end

    assign stat.mm_busy  = mm_busy_reg;
    assign stat.dv_busy  = dv_busy_reg;
    assign stat.exp_zero = (pw_exp_reg == '0);
    assign stat.exp_lsb  = pw_exp_reg[0];
    assign stat.p_lt2    = (p_reg < W'(2));
    assign stat.n_lt2    = (n_reg < W'(2));
    assign stat.r1_zero  = (r1_reg == '0);
    assign stat.r0_one   = (r0_reg == W'(1));
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign public_key = o_y_reg;
    assign sig_r      = o_r_reg;
    assign sig_s      = o_s_reg;
    assign verify_ok  = o_ok_reg;
    assign no_inverse = o_noinv_reg;

endmodule

// ===== rtl/elgamal_sign_and_verify.sv =====
// ============================================================================
// elgamal_sign_and_verify
// ElGamal signature unit: public key, signature (r, s) and a self-check flag.
// ============================================================================
//  channel   direction  handshake             payload
//  config    in/out     psel/penable/pready   paddr, pwdata, prdata
//  input     in         in_valid / in_stall   message, nonce_k
//  result    out        out_valid / out_stall public_key, sig_r, sig_s,
//                                             verify_ok, no_inverse
//
// One item at a time. Modular products run on the shared shift-and-add
// multiplier and divisions on the restoring divider. A full item runs five
// exponentiations, the Euclid inverse and the reductions.
// Reset clears the controller and the valid flags and sets the settings to
// prime 3, generator 2 and private key 0; no clearing pass.
// A new item is taken while a finished result waits under out_stall.
// ============================================================================
module elgamal_sign_and_verify
    import egsv_pkg::*;
#(
    parameter int MOD_BITS = DEF_MOD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [FIELD_BITS-1:0] message,
    input  logic [FIELD_BITS-1:0] nonce_k,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FIELD_BITS-1:0] public_key,
    output logic [FIELD_BITS-1:0] sig_r,
    output logic [FIELD_BITS-1:0] sig_s,
    output logic                  verify_ok,
    output logic                  no_inverse
);

    logic [31:0] prime_reg, generator_reg, private_reg;
    logic        wr_en;
    egsv_cmd_t   cmd;
    egsv_stat_t  stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg     <= 32'd3;
            generator_reg <= 32'd2;
            private_reg   <= 32'd0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_PRIME:     prime_reg     <= pwdata;
                REG_GENERATOR: generator_reg <= pwdata;
                REG_PRIVATE:   private_reg   <= pwdata;
                default:       prime_reg     <= prime_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_PRIME:     prdata = prime_reg;
            REG_GENERATOR: prdata = generator_reg;
            REG_PRIVATE:   prdata = private_reg;
            default:       prdata = '0;
        endcase
    end

    egsv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    egsv_dpath #(
        .MOD_BITS (MOD_BITS)
    ) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_prime     (prime_reg),
        .cfg_generator (generator_reg),
        .cfg_private   (private_reg),
        .message       (message),
        .nonce_k       (nonce_k),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .public_key    (public_key),
        .sig_r         (sig_r),
        .sig_s         (sig_s),
        .verify_ok     (verify_ok),
        .no_inverse    (no_inverse)
    );

endmodule

// ===== rtl/egsv_checker.sv =====
// ============================================================================
// egsv_checker
// Port-level checks on the signing unit, bound to the top level.
// ============================================================================
module egsv_checker
    import egsv_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [ADDR_BITS-1:0]  paddr,
    input logic [31:0]           pwdata,
    input logic [31:0]           prdata,
    input logic                  pready,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [FIELD_BITS-1:0] message,
    input logic [FIELD_BITS-1:0] nonce_k,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [FIELD_BITS-1:0] public_key,
    input logic [FIELD_BITS-1:0] sig_r,
    input logic [FIELD_BITS-1:0] sig_s,
    input logic                  verify_ok,
    input logic                  no_inverse
);

    // Once an item is taken the unit is busy with it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was taken");

    // A result never appears in the cycle straight after an item is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result raised too early");

    // A failed inverse yields no signature and no check.
    a_noinv_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_inverse |-> sig_s == '0 && !verify_ok)
        else $error("signature given without an inverse");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sig_s) && $stable(sig_r))
        else $error("stalled result dropped or changed");

endmodule

bind elgamal_sign_and_verify egsv_checker u_egsv_checker (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// ElGamal signing unit testbench
// Drives message/nonce items through the signing unit under random idling
// and stalls, predicts every result with a behavioural signer and compares
// each result field by field, across several modulus and key settings.
// ----------------------------------------------------------------------------
module tb_top;
    import egsv_pkg::*;

    typedef struct packed {
        logic [31:0] msg;
        logic [31:0] nonce;
    } sign_req_t;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] r;
        logic [31:0] s;
        logic        ok;
        logic        noinv;
    } signature_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        in_valid, in_stall;
    logic [31:0] message, nonce_k;
    logic        out_valid, out_stall;
    logic [31:0] public_key, sig_r, sig_s;
    logic        verify_ok, no_inverse;

    sign_req_t   pending_reqs[$];
    signature_t  awaited_sigs[$];
    logic [63:0] cfg_p, cfg_g, cfg_x;
    int          n_errors;
    int          n_signed;
    int          n_accepted;
    int          n_sent;
    bit          idle_enable;
    bit          hold_results;
    bit          drain_pause;

    elgamal_sign_and_verify DUT (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        return (a >= m - b) ? a - (m - b) : a + b;
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        a = a % m;
        b = b % m;
        while (b != 0)
        begin
            if (b[0])
                acc = mod_add(acc, a, m);
            a = mod_add(a, a, m);
            b = b >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        base = base % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_mul(acc, base, m);
            base = mod_mul(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Extended Euclid; returns 0 when no inverse exists.
    function automatic logic [63:0] mod_inverse(logic [63:0] a, logic [63:0] n);
        logic [63:0] r0, r1, t0, t1, q, nr, nt, qt;
        if (n < 2)
            return '0;
        r0 = n;
        r1 = a % n;
        t0 = '0;
        t1 = 64'd1;
        while (r1 != 0)
        begin
            q = r0 / r1;
            nr = r0 - q * r1;
            qt = mod_mul(q, t1, n);
            nt = (t0 >= qt) ? t0 - qt : t0 + (n - qt);
            r0 = r1;
            r1 = nr;
            t0 = t1;
            t1 = nt;
        end
        return (r0 == 1) ? t0 : '0;
    endfunction

    function automatic signature_t sign_message(sign_req_t req);
        signature_t  res;
        logic [63:0] n, kinv, xr, mr, diff, s, lhs;
        res = '0;
        res.noinv = 1'b1;
        if (cfg_p >= 2)
        begin
            n = cfg_p - 1;
            res.y = 32'(mod_pow(cfg_g, cfg_x, cfg_p));
            res.r = 32'(mod_pow(cfg_g, 64'(req.nonce), cfg_p));
            kinv = mod_inverse(64'(req.nonce), n);
            if (kinv != 0)
            begin
                mr = 64'(req.msg) % n;
                xr = mod_mul(cfg_x, 64'(res.r), n);
                diff = (mr >= xr) ? mr - xr : mr + (n - xr);
                s = mod_mul(diff, kinv, n);
                if (s == 0)
                    s = n;
                res.s = 32'(s);
                res.noinv = 1'b0;
                lhs = mod_mul(mod_pow(64'(res.y), 64'(res.r), cfg_p),
                              mod_pow(64'(res.r), s, cfg_p), cfg_p);
                res.ok = (lhs == mod_pow(cfg_g, 64'(req.msg), cfg_p));
            end
        end
        return res;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PRIME:     cfg_p = 64'(val);
            REG_GENERATOR: cfg_g = 64'(val);
            REG_PRIVATE:   cfg_x = 64'(val);
            default: ;
        endcase
    endtask

    // Waits until the sender and the result store are both empty.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || awaited_sigs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Driver: presents items from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            message  <= '0;
            nonce_k  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_reqs.size() != 0 && !drain_pause
                && !(idle_enable && $urandom_range(99) < 24))
            begin
                sign_req_t req;
                req = pending_reqs.pop_front();
                in_valid <= 1'b1;
                message  <= req.msg;
                nonce_k  <= req.nonce;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Prediction is made at acceptance, with the settings then in force.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            awaited_sigs.insert(awaited_sigs.size(),
                                sign_message('{msg: message, nonce: nonce_k}));
            n_accepted <= n_accepted + 1;
        end
    end

    // Receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_results || (idle_enable && $urandom_range(99) < 24);
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_sigs.size() == 0)
            begin
                $error("result arrived with none expected");
                n_errors++;
            end
            else
            begin
                signature_t exp_sig;
                exp_sig = awaited_sigs.pop_front();
                n_signed++;
                if (public_key !== exp_sig.y)
                begin
                    $error("public_key expected %h actual %h", exp_sig.y, public_key);
                    n_errors++;
                end
                if (sig_r !== exp_sig.r)
                begin
                    $error("sig_r expected %h actual %h", exp_sig.r, sig_r);
                    n_errors++;
                end
                if (sig_s !== exp_sig.s)
                begin
                    $error("sig_s expected %h actual %h", exp_sig.s, sig_s);
                    n_errors++;
                end
                if (verify_ok !== exp_sig.ok)
                begin
                    $error("verify_ok expected %b actual %b", exp_sig.ok, verify_ok);
                    n_errors++;
                end
                if (no_inverse !== exp_sig.noinv)
                begin
                    $error("no_inverse expected %b actual %b", exp_sig.noinv, no_inverse);
                    n_errors++;
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles here.
    initial
    begin
        hold_results = 1'b0;
        wait (n_sent >= 40);
        hold_results = 1'b1;
        repeat (60000) @(posedge clk);
        hold_results = 1'b0;
    end

    initial
    begin
        // Timeout for 150 items and the hold-off, set with ample margin.
        #200000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic queue_item(logic [31:0] m, logic [31:0] k);
        pending_reqs.insert(pending_reqs.size(), '{msg: m, nonce: k});
        n_sent++;
    endtask

    task automatic random_items(int count);
        logic [31:0] k;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0: k = $urandom_range(30, 1);
                1: k = $urandom() | 32'h1;
                default: k = $urandom();
            endcase
            if (k == 0)
                k = 1;
            queue_item($urandom(), k);
        end
    endtask

    initial
    begin
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        n_errors = 0; n_signed = 0; n_accepted = 0; n_sent = 0;
        idle_enable = 1'b1;
        drain_pause = 1'b0;
        cfg_p = 3; cfg_g = 2; cfg_x = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings first, then a small prime with directed items.
        queue_item(32'd5, 32'd1);
        queue_item(32'hFFFF_FFFF, 32'd2);
        wait_drained();
        write_reg(REG_PRIME, 32'd23);
        write_reg(REG_GENERATOR, 32'd5);
        write_reg(REG_PRIVATE, 32'd6);
        queue_item(32'd0, 32'd1);
        queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(32'd7, 32'd2);
        queue_item(32'd10, 32'd3);
        queue_item(32'd6, 32'd21);
        queue_item(32'h8000_0000, 32'h8000_0001);
        for (int m = 0; m < 6; m++)
            queue_item(32'(m), 32'd7);
        wait_drained();

        // Modulus below two, then modulus two.
        write_reg(REG_PRIME, 32'd0);
        queue_item(32'd3, 32'd5);
        wait_drained();
        write_reg(REG_PRIME, 32'd1);
        queue_item(32'd3, 32'd5);
        wait_drained();
        write_reg(REG_PRIME, 32'd2);
        write_reg(REG_GENERATOR, 32'd1);
        queue_item(32'd9, 32'd1);
        queue_item(32'd0, 32'hFFFF_FFFF);
        wait_drained();

        // Largest 32-bit prime with extreme generator and key.
        write_reg(REG_PRIME, 32'hFFFF_FFFB);
        write_reg(REG_GENERATOR, 32'hFFFF_FFFF);
        write_reg(REG_PRIVATE, 32'hFFFF_FFFF);
        queue_item(32'hFFFF_FFFF, 32'd3);
        queue_item(32'h0000_0000, 32'h7FFF_FFFF);
        wait_drained();

        // Random phases: no idling for a stretch, during which the receiver hold-off begins.
        write_reg(REG_GENERATOR, 32'd2);
        write_reg(REG_PRIVATE, $urandom());
        idle_enable = 1'b0;
        random_items(30);
        wait_drained();
        idle_enable = 1'b1;
        write_reg(REG_PRIME, 32'd1_000_003);
        write_reg(REG_GENERATOR, 32'd2);
        write_reg(REG_PRIVATE, $urandom());
        random_items(40);
        wait (pending_reqs.size() == 0);
        drain_pause = 1'b1;
        wait_drained();
        drain_pause = 1'b0;
        write_reg(REG_PRIME, 32'hFFFF_FFFF);
        write_reg(REG_GENERATOR, $urandom());
        write_reg(REG_PRIVATE, 32'd0);
        random_items(30);
        wait_drained();
        write_reg(REG_PRIME, 32'd65537);
        write_reg(REG_GENERATOR, 32'd3);
        write_reg(REG_PRIVATE, $urandom());
        random_items(30);
        wait_drained();
        repeat (200) @(posedge clk);

        $display("Signed %0d items over several modulus, generator and key settings,",
                 n_signed);
        $display("including degenerate moduli, non-invertible nonces and long stalls.");
        if (n_errors == 0 && awaited_sigs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
